// ----- rtl/ptbl_pkg.sv -----
// Shared types and constants for the per-slot token bucket limiter.
package ptbl_pkg;

    localparam int CAP_W      = 16;
    localparam int RATE_W     = 32;
    localparam int TIME_W     = 48;
    localparam int HALF_W     = TIME_W / 2;
    localparam int MULP_W     = RATE_W + HALF_W;
    localparam int PROD_W     = RATE_W + TIME_W;
    localparam int SLOT_W     = 8;
    localparam int SLOT_RANGE = 2 ** SLOT_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ID_CAP    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ID_REFILL = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IP_CAP    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IP_REFILL = 8'd3;

    // Controller to datapath commands: at most one is active per cycle.
    typedef struct packed {
        logic clear_en;
        logic accept_en;
        logic load_en;
        logic mul_lo_en;
        logic mul_hi_en;
        logic sum_en;
        logic refill_en;
        logic commit_en;
    } ptbl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_busy;
    } ptbl_sts_t;

endpackage

// ----- rtl/ptbl_ctrl.sv -----
// Sequencer for the limiter: clearing pass, then one request at a time.
module ptbl_ctrl
    import ptbl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  ptbl_sts_t  sts,
    output ptbl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_REFILL,
        ST_TAKE
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid && s_tready_reg) begin
                    cmd.accept_en = 1'b1;
                    state_next    = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load_en = 1'b1;
                state_next  = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                cmd.mul_lo_en = 1'b1;
                state_next    = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.mul_hi_en = 1'b1;
                state_next    = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum_en = 1'b1;
                state_next = ST_REFILL;
            end
            ST_REFILL: begin
                cmd.refill_en = 1'b1;
                state_next    = ST_TAKE;
            end
            ST_TAKE: begin
                // hold until the output register can take the result
                if (!sts.out_busy) begin
                    cmd.commit_en = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            s_tready_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_tready = s_tready_reg;

    a_cmd_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("ptbl_ctrl: more than one datapath command active");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit_en |-> !sts.out_busy)
        else $error("ptbl_ctrl: result committed over a held beat");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept_en |=> !s_tready)
        else $error("ptbl_ctrl: second beat accepted while busy");

endmodule

// ----- rtl/ptbl_dp.sv -----
// Datapath: config registers, bucket memory, refill arithmetic and result register.
module ptbl_dp
    import ptbl_pkg::*;
#(
    parameter int SLOTS         = 256,
    parameter int FRACTION_BITS = 40
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,
    input  ptbl_cmd_t             cmd,
    output ptbl_sts_t             sts
);

    localparam int DEPTH  = 2 * SLOTS;
    localparam int AW     = $clog2(DEPTH);
    localparam int SW     = $clog2(SLOTS);
    localparam int TW     = CAP_W + FRACTION_BITS;
    localparam int WORD_W = 1 + TW + TIME_W;
    localparam logic [TW-1:0] ONE = TW'(1) << FRACTION_BITS;

    typedef logic [SW-1:0] mod_tab_t [SLOT_RANGE];

    function automatic mod_tab_t build_mod_tab();
        mod_tab_t t;
        for (int i = 0; i < SLOT_RANGE; i++) begin
            t[i] = SW'(i % SLOTS);
        end
        return t;
    endfunction

    localparam mod_tab_t MOD_TAB = build_mod_tab();

    // config registers
    logic [CAP_W-1:0]  id_cap_reg, ip_cap_reg;
    logic [RATE_W-1:0] id_refill_reg, ip_refill_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_cap_reg    <= '0;
            id_refill_reg <= '0;
            ip_cap_reg    <= '0;
            ip_refill_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_ID_CAP:    id_cap_reg    <= cfg_data[CAP_W-1:0];
                REG_ID_REFILL: id_refill_reg <= cfg_data[RATE_W-1:0];
                REG_IP_CAP:    ip_cap_reg    <= cfg_data[CAP_W-1:0];
                REG_IP_REFILL: ip_refill_reg <= cfg_data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // request fields
    logic [SLOT_W-1:0] in_slot;
    logic [TIME_W-1:0] in_now;
    logic [AW-1:0]     in_addr;

    assign in_slot = s_tdata[SLOT_W-1:0];
    assign in_now  = s_tdata[SLOT_W +: TIME_W];
    assign in_addr = AW'(MOD_TAB[in_slot]) + (s_tuser ? AW'(SLOTS) : AW'(0));

    // bucket memory: {valid, tokens, last time}
    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_word_reg;
    logic [AW-1:0]     clr_cnt_reg;
    logic [AW-1:0]     addr_reg;
    logic [TIME_W-1:0] now_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [TW-1:0]     cap_fx_reg;
    logic              bypass_reg;
    logic [TW-1:0]     new_tok_reg;
    logic              take;
    logic [TW-1:0]     wr_tok;

    assign take   = (new_tok_reg[TW-1:FRACTION_BITS] != '0);
    assign wr_tok = take ? (new_tok_reg - ONE) : new_tok_reg;

    always_ff @(posedge aclk) begin
        if (cmd.clear_en) begin
            mem[clr_cnt_reg] <= '0;
        end else if (cmd.commit_en && !bypass_reg) begin
            mem[addr_reg] <= {1'b1, wr_tok, now_reg};
        end
        if (cmd.accept_en) begin
            rd_word_reg <= mem[in_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_en && !sts.clear_last) begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    assign sts.clear_last = (clr_cnt_reg == AW'(DEPTH - 1));

    // capture the request and the class settings
    always_ff @(posedge aclk) begin
        if (cmd.accept_en) begin
            addr_reg   <= in_addr;
            now_reg    <= in_now;
            rate_reg   <= s_tuser ? ip_refill_reg : id_refill_reg;
            cap_fx_reg <= {(s_tuser ? ip_cap_reg : id_cap_reg), FRACTION_BITS'(0)};
            bypass_reg <= s_tuser && (ip_refill_reg == '0);
        end
    end

    // unpack the stored entry, find elapsed time and headroom
    logic              rd_valid;
    logic [TW-1:0]     rd_tok;
    logic [TIME_W-1:0] rd_last;
    logic              valid_reg, full_reg;
    logic [TW-1:0]     tok_reg, room_reg;
    logic [TIME_W-1:0] elapsed_reg;

    assign rd_valid = rd_word_reg[WORD_W-1];
    assign rd_tok   = rd_word_reg[TIME_W +: TW];
    assign rd_last  = rd_word_reg[TIME_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load_en) begin
            valid_reg   <= rd_valid;
            tok_reg     <= rd_tok;
            full_reg    <= (rd_tok >= cap_fx_reg);
            room_reg    <= cap_fx_reg - rd_tok;
            // time running backwards counts as no time
            elapsed_reg <= (now_reg > rd_last) ? (now_reg - rd_last) : '0;
        end
    end

    // shared multiplier: low half of elapsed, then high half
    logic [HALF_W-1:0] mul_b;
    logic [MULP_W-1:0] mul_p;
    logic [MULP_W-1:0] prod_lo_reg, prod_hi_reg;
    logic [PROD_W-1:0] prod_reg;

    assign mul_b = cmd.mul_hi_en ? elapsed_reg[TIME_W-1:HALF_W] : elapsed_reg[HALF_W-1:0];
    assign mul_p = MULP_W'(rate_reg) * MULP_W'(mul_b);

    always_ff @(posedge aclk) begin
        if (cmd.mul_lo_en) begin
            prod_lo_reg <= mul_p;
        end
        if (cmd.mul_hi_en) begin
            prod_hi_reg <= mul_p;
        end
        if (cmd.sum_en) begin
            prod_reg <= (PROD_W'(prod_hi_reg) << HALF_W) + PROD_W'(prod_lo_reg);
        end
    end

    // refill and cap: first use, a bucket already at capacity or any overflow leaves the bucket full
    always_ff @(posedge aclk) begin
        if (cmd.refill_en) begin
            if (!valid_reg || full_reg || (prod_reg >= PROD_W'(room_reg))) begin
                new_tok_reg <= cap_fx_reg;
            end else begin
                new_tok_reg <= tok_reg + prod_reg[TW-1:0];
            end
        end
    end

    // result register
    logic m_tvalid_reg;
    logic allowed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.commit_en) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit_en) begin
            allowed_reg <= bypass_reg || take;
        end
    end

    assign sts.out_busy = m_tvalid_reg && !m_tready;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = {{(M_DATA_W-1){1'b0}}, allowed_reg};

endmodule

// ----- rtl/per_slot_token_bucket_limiter.sv -----
// One request in flight: each beat steps through LOAD, MUL_LO, MUL_HI, SUM, REFILL and
// TAKE before the next is taken, set by the single read-modify-write of the
// bucket memory and the shared 32x24 multiplier used twice per request.
// A held result does not block the next request until its own result is ready.
// Reset (aresetn low, synchronous) zeroes the config registers, then a clearing pass
// wipes all 2*SLOTS bucket entries; s_tready stays low until it ends.
module per_slot_token_bucket_limiter
    import ptbl_pkg::*;
#(
    parameter int SLOTS         = 256,
    parameter int FRACTION_BITS = 40
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // config write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // slot[7:0], now_time[55:8]
    input  logic                  s_tuser,   // kind
    // decision stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata    // allowed[0], zero fill [7:1]
);

    ptbl_cmd_t cmd;
    ptbl_sts_t sts;

    assign cfg_ready = 1'b1;

    ptbl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ptbl_dp #(
        .SLOTS         (SLOTS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ----- tb/per_slot_token_bucket_limiter_tb.sv -----
// Self-checking testbench for the per-slot token bucket limiter, with its own bucket predictor.
module per_slot_token_bucket_limiter_tb
    import ptbl_pkg::*;
;

    localparam int          FRACTION_BITS = 40;
    localparam int          TOTAL_BUCKETS = 2 * SLOT_RANGE;
    localparam logic [63:0] ONE_TOKEN     = 64'd1 << FRACTION_BITS;
    localparam int          LATENCY       = 7;
    localparam int          STALL_LIMIT   = 4000;
    localparam int          PHASE_ITEMS   = 290;

    typedef enum bit {
        KIND_IDENTITY = 1'b0,
        KIND_IP       = 1'b1
    } req_kind_t;

    class bucket_scoreboard_t;
        logic [CAP_W-1:0]  capacity [2];
        logic [RATE_W-1:0] refill [2];
        bit                valid_mark [TOTAL_BUCKETS];
        logic [63:0]       level_fx [TOTAL_BUCKETS];
        logic [TIME_W-1:0] last_seen [TOTAL_BUCKETS];
        bit                decision_q [$];
        int                mismatches;

        function new();
            foreach (valid_mark[i]) begin
                valid_mark[i] = 1'b0;
                level_fx[i]   = '0;
                last_seen[i]  = '0;
            end
            foreach (capacity[k]) begin
                capacity[k] = '0;
                refill[k]   = '0;
            end
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            case (index)
                REG_ID_CAP:    capacity[KIND_IDENTITY] = value[CAP_W-1:0];
                REG_ID_REFILL: refill[KIND_IDENTITY]   = value[RATE_W-1:0];
                REG_IP_CAP:    capacity[KIND_IP]       = value[CAP_W-1:0];
                REG_IP_REFILL: refill[KIND_IP]         = value[RATE_W-1:0];
                default: ;
            endcase
        endfunction

        // Refill, cap, take one token (ip bypass at zero refill); queue the decision to expect.
        function void note_request(req_kind_t kind, logic [SLOT_W-1:0] slot,
                                   logic [TIME_W-1:0] now);
            int unsigned       entry;
            logic [63:0]       cap_fx;
            logic [63:0]       room;
            logic [63:0]       level;
            logic [TIME_W-1:0] elapsed;
            logic [PROD_W-1:0] gain;
            bit                granted;
            entry = int'(kind) * SLOT_RANGE + int'(slot);
            if (kind == KIND_IP && refill[KIND_IP] == '0) begin
                decision_q.push_back(1'b1);
                return;
            end
            cap_fx = 64'(capacity[kind]) << FRACTION_BITS;
            if (!valid_mark[entry]) begin
                level = cap_fx;
                valid_mark[entry] = 1'b1;
            end else begin
                elapsed = (now > last_seen[entry]) ? now - last_seen[entry] : '0;
                gain = PROD_W'(refill[kind]) * PROD_W'(elapsed);
                if (level_fx[entry] >= cap_fx) begin
                    level = cap_fx;
                end else begin
                    room = cap_fx - level_fx[entry];
                    if (gain >= PROD_W'(room))
                        level = cap_fx;
                    else
                        level = level_fx[entry] + gain[63:0];
                end
            end
            last_seen[entry] = now;
            granted = (level >= ONE_TOKEN);
            if (granted)
                level = level - ONE_TOKEN;
            level_fx[entry] = level;
            decision_q.push_back(granted);
        endfunction

        function void check_decision(logic allowed);
            bit want;
            if (decision_q.size() == 0) begin
                $error("allowed: no decision expected, actual %0b", allowed);
                mismatches++;
                return;
            end
            want = decision_q.pop_front();
            if (allowed !== want) begin
                $error("allowed: expected %0b, actual %0b", want, allowed);
                mismatches++;
            end
        endfunction

        function int pending();
            return decision_q.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;   // slot[7:0], now_time[55:8]
    logic                  s_tuser;   // kind
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;   // allowed[0], zero fill [7:1]

    bucket_scoreboard_t    sb = new();
    int                    idle_cycles;
    logic [TIME_W-1:0]     req_time [2];

    per_slot_token_bucket_limiter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Check results before noting new requests so one edge never reorders the queue.
    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles <= 0;
        end else begin
            if (m_tvalid && m_tready)
                sb.check_decision(m_tdata[0]);
            if (s_tvalid && s_tready)
                sb.note_request(req_kind_t'(s_tuser), s_tdata[SLOT_W-1:0],
                                s_tdata[SLOT_W +: TIME_W]);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("per_slot_token_bucket_limiter regression: fail");
                $finish;
            end
        end
    end

    // Receiver: alternate ready and stall runs of random length.
    initial begin
        bit ready_phase;
        int run_left;
        ready_phase = 1'b0;
        run_left    = 0;
        m_tready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (run_left == 0) begin
                ready_phase = !ready_phase;
                run_left = ready_phase ? $urandom_range(1, 40) : $urandom_range(1, 12);
            end
            run_left--;
            m_tready <= ready_phase;
        end
    end

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_register(index, value);
        @(negedge aclk);
    endtask

    // Reconfigure only once the block is idle: drain, then let the pipeline settle.
    task automatic configure(input logic [CAP_W-1:0] id_cap, input logic [RATE_W-1:0] id_rate,
                             input logic [CAP_W-1:0] ip_cap, input logic [RATE_W-1:0] ip_rate);
        wait_drained();
        repeat (LATENCY + 2) @(negedge aclk);
        write_register(REG_ID_CAP, CFG_DATA_W'(id_cap));
        write_register(REG_ID_REFILL, id_rate);
        write_register(REG_IP_CAP, CFG_DATA_W'(ip_cap));
        write_register(REG_IP_REFILL, ip_rate);
        cfg_valid <= 1'b0;
    endtask

    // Leaves s_tvalid high so a burst runs on without a gap.
    task automatic send_request(input req_kind_t kind, input logic [SLOT_W-1:0] slot,
                                input logic [TIME_W-1:0] now);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {now, slot};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    function automatic logic [CAP_W-1:0] pick_capacity();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return CAP_W'($urandom_range(0, 65535));
            default: return CAP_W'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return RATE_W'(1);
            3:       return $urandom();
            default: return $urandom_range(32'h0100_0000, 32'h4000_0000);
        endcase
    endfunction

    task automatic run_phase(input int count, input bit pause_midway);
        int                sent;
        int                burst;
        int                gap;
        bit                paused;
        req_kind_t         kind;
        logic [SLOT_W-1:0] slot;
        sent   = 0;
        paused = 1'b0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && sent < count; b++) begin
                kind = req_kind_t'($urandom_range(0, 1));
                // Mostly a handful of slots so buckets drain and refill.
                if ($urandom_range(0, 4) == 0)
                    slot = SLOT_W'($urandom_range(0, 255));
                else
                    slot = SLOT_W'($urandom_range(0, 7));
                case ($urandom_range(0, 19))
                    0:       req_time[kind] = req_time[kind] + TIME_W'($urandom());
                    1:       req_time[kind] = req_time[kind] - TIME_W'($urandom_range(0, 500));
                    2:       req_time[kind] = TIME_W'({$urandom(), $urandom()});
                    default: req_time[kind] = req_time[kind] + TIME_W'($urandom_range(0, 300));
                endcase
                send_request(kind, slot, req_time[kind]);
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (pause_midway && !paused && sent >= count / 2) begin
                paused = 1'b1;
                s_tvalid <= 1'b0;
                wait_drained();
            end else if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        req_time[0] = '0;
        req_time[1] = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Ip bypass, first use at full capacity, time and slot extremes.
        configure(16'hFFFF, '0, '0, '0);
        send_request(KIND_IDENTITY, 8'd0, '0);
        send_request(KIND_IDENTITY, 8'd255, '1);
        send_request(KIND_IP, 8'd255, '0);
        send_request(KIND_IP, 8'd0, '1);
        send_request(KIND_IDENTITY, 8'd7, 48'd100);
        s_tvalid <= 1'b0;

        // Lowered capacity, time going backwards, fractional refill, product overflow.
        configure(16'd1, '1, '0, 32'd1);
        send_request(KIND_IDENTITY, 8'd7, 48'd50);
        send_request(KIND_IDENTITY, 8'd7, 48'd50);
        send_request(KIND_IDENTITY, 8'd7, 48'd306);
        send_request(KIND_IDENTITY, 8'd7, 48'd307);
        send_request(KIND_IDENTITY, 8'd0, '1);
        send_request(KIND_IP, 8'd3, 48'd10);
        send_request(KIND_IP, 8'd3, '1);
        s_tvalid <= 1'b0;

        // Zero identity capacity; ip bucket refilled from empty to full.
        configure('0, '0, 16'hFFFF, '1);
        send_request(KIND_IDENTITY, 8'd255, 48'd5);
        send_request(KIND_IP, 8'd3, '0);
        send_request(KIND_IP, 8'd3, '1);
        send_request(KIND_IP, 8'd128, 48'd1);
        s_tvalid <= 1'b0;

        configure('1, '1, '1, '1);
        run_phase(PHASE_ITEMS, 1'b0);
        configure('0, '0, '0, '0);
        run_phase(PHASE_ITEMS, 1'b1);
        repeat (4) begin
            configure(pick_capacity(), pick_rate(), pick_capacity(), pick_rate());
            run_phase(PHASE_ITEMS, 1'b1);
        end

        wait_drained();
        repeat (LATENCY + 4) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("per_slot_token_bucket_limiter regression: pass");
        else
            $display("per_slot_token_bucket_limiter regression: fail");
        $finish;
    end

endmodule
